// ----- rtl/core/bbc_pkg.sv -----
// ----------------------------------------------------------------------------
// bbc_pkg
// Shared types and constants of the bracket balance checker: character codes,
// bracket type codes, verdict codes and the character classifier.
// ----------------------------------------------------------------------------
package bbc_pkg;

   // bracket type code as stored on the stack
   typedef logic [1:0] code_type;

   localparam code_type CODE_PAREN = 2'd0;
   localparam code_type CODE_SQUARE = 2'd1;
   localparam code_type CODE_CURLY = 2'd2;

   // characters of interest
   localparam logic [7:0] CHAR_OPEN_PAREN = 8'h28;
   localparam logic [7:0] CHAR_CLOSE_PAREN = 8'h29;
   localparam logic [7:0] CHAR_OPEN_SQUARE = 8'h5b;
   localparam logic [7:0] CHAR_CLOSE_SQUARE = 8'h5d;
   localparam logic [7:0] CHAR_OPEN_CURLY = 8'h7b;
   localparam logic [7:0] CHAR_CLOSE_CURLY = 8'h7d;

   // verdict codes
   typedef logic [1:0] verdict_type;

   localparam verdict_type VERDICT_PENDING = 2'd0;
   localparam verdict_type VERDICT_VALID = 2'd1;
   localparam verdict_type VERDICT_INVALID = 2'd2;
   localparam verdict_type VERDICT_OVERFLOW = 2'd3;

   // class of one character
   typedef struct packed {
      logic     is_open;
      logic     is_close;
      code_type code;
   } char_class_type;

   // one result item
   typedef struct packed {
      verdict_type verdict;
      logic        string_done;
   } result_type;

   // classify a raw byte as opening bracket, closing bracket or other
   function automatic char_class_type classify(input logic [7:0] ch);
      char_class_type cls;
      cls = '{is_open: 1'b0, is_close: 1'b0, code: CODE_PAREN};
      unique case (ch)
         CHAR_OPEN_PAREN: begin
            cls.is_open = 1'b1;
            cls.code = CODE_PAREN;
         end
         CHAR_OPEN_SQUARE: begin
            cls.is_open = 1'b1;
            cls.code = CODE_SQUARE;
         end
         CHAR_OPEN_CURLY: begin
            cls.is_open = 1'b1;
            cls.code = CODE_CURLY;
         end
         CHAR_CLOSE_PAREN: begin
            cls.is_close = 1'b1;
            cls.code = CODE_PAREN;
         end
         CHAR_CLOSE_SQUARE: begin
            cls.is_close = 1'b1;
            cls.code = CODE_SQUARE;
         end
         CHAR_CLOSE_CURLY: begin
            cls.is_close = 1'b1;
            cls.code = CODE_CURLY;
         end
         default: begin
            cls.is_open = 1'b0;
         end
      endcase
      return cls;
   endfunction

endpackage

// ----- rtl/core/bbc_ram.sv -----
// ----------------------------------------------------------------------------
// bbc_ram
// Generic single-write, single-read synchronous RAM with a registered read
// port. Contents are undefined until written.
// ----------------------------------------------------------------------------
module bbc_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/bracket_balance_checker.sv -----
// ----------------------------------------------------------------------------
// bracket_balance_checker
// Checks bracket balance over a stream of characters, one per transfer.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch / req_end_of_string carry one character per transfer; the last
//   character of a string has req_end_of_string set. Every request transfer
//   yields exactly one response transfer on rsp_verdict / rsp_string_done.
//   Opening brackets push their type on a stack held in a RAM of STACK_DEPTH
//   entries, any other character pops it; the top entry is cached in a
//   register and the entry below it is prefetched from the RAM every cycle,
//   so a push or pop never waits for a RAM read.
//   The response is registered in the output register, or in the skid buffer
//   when the receiver stalls. Throughput: one character per cycle while
//   req_stall is low (one RAM write and one RAM read per cycle).
//   The response side has an output register plus a one-entry skid buffer;
//   req_stall rises only when both hold results, i.e. after the receiver
//   has stalled for two results.
//   Reset (synchronous, active high) clears stack depth, fault flags and
//   the response buffers; RAM contents are not cleared and need no pass.
// ----------------------------------------------------------------------------
module bracket_balance_checker #(
   parameter int STACK_DEPTH = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_ch,
   input  logic       req_end_of_string,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_verdict,
   output logic       rsp_string_done
);

   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CW = $clog2(STACK_DEPTH + 1);

   // stack state
   logic [CW-1:0]         count_ff, count_in;
   bbc_pkg::code_type     top_ff, top_in;
   logic                  failed_ff, failed_in;
   logic                  overflow_ff, overflow_in;

   // ram ports
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [AW-1:0]         rd_addr;
   bbc_pkg::code_type     below_data;

   // response buffers
   bbc_pkg::result_type   main_ff, main_in;
   bbc_pkg::result_type   skid_ff, skid_in;
   logic                  main_valid_ff, main_valid_in;
   logic                  skid_valid_ff, skid_valid_in;

   logic                  req_take;
   logic                  rsp_take;
   bbc_pkg::char_class_type cls;
   bbc_pkg::result_type   result;

   assign req_stall = skid_valid_ff;
   assign req_take = req_valid && !req_stall;
   assign rsp_take = main_valid_ff && !rsp_stall;
   assign cls = bbc_pkg::classify(req_ch);

   // stack ram: entry at count-1 mirrors the cached top
   bbc_ram #(
      .WIDTH ($bits(bbc_pkg::code_type)),
      .DEPTH (STACK_DEPTH)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (cls.code),
      .rd_addr (rd_addr),
      .rd_data (below_data)
   );

   assign wr_addr = count_ff[AW-1:0];

   // prefetch the entry below the next top
   assign rd_addr = AW'(count_in - CW'(2));

   // push / pop and verdict
   always_comb begin
      count_in = count_ff;
      top_in = top_ff;
      failed_in = failed_ff;
      overflow_in = overflow_ff;
      wr_en = 1'b0;
      if (req_take && !failed_ff && !overflow_ff) begin
         if (cls.is_open) begin
            if (count_ff == CW'(STACK_DEPTH)) begin
               overflow_in = 1'b1;
            end else begin
               wr_en = 1'b1;
               count_in = count_ff + CW'(1);
               top_in = cls.code;
            end
         end else if (count_ff == '0) begin
            failed_in = 1'b1;
         end else begin
            count_in = count_ff - CW'(1);
            top_in = below_data;
            if (cls.is_close && (cls.code != top_ff)) begin
               failed_in = 1'b1;
            end
         end
      end

      priority if (overflow_in) begin
         result.verdict = bbc_pkg::VERDICT_OVERFLOW;
      end else if (failed_in) begin
         result.verdict = bbc_pkg::VERDICT_INVALID;
      end else if (req_end_of_string) begin
         result.verdict = (count_in == '0) ? bbc_pkg::VERDICT_VALID
                                           : bbc_pkg::VERDICT_INVALID;
      end else begin
         result.verdict = bbc_pkg::VERDICT_PENDING;
      end
      result.string_done = req_end_of_string;

      // end of string clears the state
      if (req_take && req_end_of_string) begin
         count_in = '0;
         failed_in = 1'b0;
         overflow_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         failed_ff <= 1'b0;
         overflow_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         failed_ff <= failed_in;
         overflow_ff <= overflow_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff <= top_in;
   end

   // output register and skid buffer
   always_comb begin
      main_in = main_ff;
      skid_in = skid_ff;
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (rsp_take) begin
            main_in = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (req_take) begin
         if (!main_valid_ff || rsp_take) begin
            main_in = result;
            main_valid_in = 1'b1;
         end else begin
            skid_in = result;
            skid_valid_in = 1'b1;
         end
      end else if (rsp_take) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid = main_valid_ff;
   assign rsp_verdict = main_ff.verdict;
   assign rsp_string_done = main_ff.string_done;

   // depth never exceeds the stack size
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(STACK_DEPTH))
      else $error("stack count beyond depth");

   // an overflow only happens on a full stack, which then stays frozen
   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      overflow_ff |-> (count_ff == CW'(STACK_DEPTH)))
      else $error("overflow flag with stack not full");

   // the first fault freezes the stack, so both flags never coexist
   a_one_fault: assert property (@(posedge clock) disable iff (reset)
      !(failed_ff && overflow_ff))
      else $error("both fault flags set");

   // end of string leaves a clean state
   a_clear_at_end: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_end_of_string) |=>
         (count_ff == '0 && !failed_ff && !overflow_ff))
      else $error("state not cleared after end of string");

   // skid entry only exists behind a waiting result
   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid buffer holds a result with empty output register");

endmodule
